// File: rtl/lzwu_pkg.sv
// Shared types, constants and the symbol mapping for the LZW compressor.
// Used by the top level, the controller and the datapath; depends on nothing.
package lzwu_pkg;

    localparam int CODE_BITS_DEF   = 12;
    localparam int MAX_LEN_DEF     = 16;
    localparam int SYM_W           = 16;
    localparam int BASE_W          = 8;
    localparam int LEN_W           = 8;
    localparam int OUT_CODE_W      = 12;
    localparam int FIRST_FREE      = 256;
    localparam int IN_DATA_W       = 16;
    localparam int OUT_DATA_W      = 16;
    localparam int OUT_USER_W      = 1;

    localparam logic [7:0] ASCII_MAX  = 8'h7f;
    localparam logic [7:0] ASCII_MIN  = 8'h01;
    localparam logic [7:0] LEAD_LOW   = 8'hc2;
    localparam logic [7:0] LEAD_HIGH  = 8'hc3;
    localparam logic [7:0] TRAIL_MIN  = 8'h80;
    localparam logic [7:0] TRAIL_MAX  = 8'hbf;

    typedef struct packed {
        logic accept;
        logic set_base;
        logic scan_start;
        logic rd_en;
        logic scan_inc;
        logic take_hit;
        logic take_miss;
        logic bad_res;
        logic push_pend;
        logic push_flush;
        logic push_final;
        logic clear_stream;
    } lzwu_cmd_t;

    typedef struct packed {
        logic b_zero;
        logic cur_zero;
        logic dict_empty;
        logic hit;
        logic scan_last;
        logic last;
        logic pend;
        logic out_free;
    } lzwu_stat_t;

    // Maps a symbol to its base code 1..255, or 0 outside the alphabet.
    function automatic logic [BASE_W-1:0] base_code(input logic [SYM_W-1:0] s);
        logic [7:0] lead;
        logic [7:0] trail;
        logic [BASE_W-1:0] r;
        lead  = s[15:8];
        trail = s[7:0];
        r     = '0;
        if (lead == 8'h00 && trail >= ASCII_MIN && trail <= ASCII_MAX) begin
            r = trail;
        end else if (trail >= TRAIL_MIN && trail <= TRAIL_MAX) begin
            if (lead == LEAD_LOW) begin
                r = {2'b10, trail[5:0]};
            end else if (lead == LEAD_HIGH) begin
                r = {2'b11, trail[5:0]};
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/lzw_utf8_compressor_top.sv
// LZW compressor top level. From acceptance until ready returns, an item passes
// through the decide state, a read and a compare state per dictionary entry scanned
// (codes 256 up to the next free code), the finish state, a push state for each
// result it emits (at most 2) and the done state. A full output register stalls
// the item until the result is taken. The first result is registered after the scan.
// Reset is synchronous and active low; it empties the string and dictionary.
module lzw_utf8_compressor_top #(
    parameter int CODE_BITS      = lzwu_pkg::CODE_BITS_DEF,
    parameter int MAX_STRING_LEN = lzwu_pkg::MAX_LEN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lzwu_pkg::IN_DATA_W-1:0]  s_tdata,   // symbol[15:0]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lzwu_pkg::OUT_DATA_W-1:0] m_tdata,   // code[11:0], zeros above
    output logic [lzwu_pkg::OUT_USER_W-1:0] m_tuser,   // bad_symbol[0]
    output logic                            m_tlast
);
    import lzwu_pkg::*;

    lzwu_cmd_t  cmd;
    lzwu_stat_t stat;

    lzwu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lzwu_dpath #(
        .CODE_BITS     (CODE_BITS),
        .MAX_STRING_LEN(MAX_STRING_LEN)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .cmd     (cmd),
        .stat    (stat)
    );
endmodule

// File: rtl/lzwu_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module lzwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: rtl/lzwu_ctrl.sv
// Controller state machine of the LZW compressor.
// Depends on lzwu_pkg; drives the datapath by command and reads its status.
module lzwu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lzwu_pkg::lzwu_stat_t stat,
    output lzwu_pkg::lzwu_cmd_t  cmd
);
    import lzwu_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECIDE = 8'b0000_0010,
        ST_RD     = 8'b0000_0100,
        ST_CMP    = 8'b0000_1000,
        ST_FIN    = 8'b0001_0000,
        ST_PUSHP  = 8'b0010_0000,
        ST_PUSHF  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.b_zero) begin
                    cmd.bad_res = 1'b1;
                    state_next  = ST_FIN;
                end else if (stat.cur_zero) begin
                    cmd.set_base = 1'b1;
                    state_next   = ST_FIN;
                end else if (stat.dict_empty) begin
                    cmd.take_miss = 1'b1;
                    state_next    = ST_FIN;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_RD;
                end
            end
            ST_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (stat.hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_FIN;
                end else if (stat.scan_last) begin
                    cmd.take_miss = 1'b1;
                    state_next    = ST_FIN;
                end else begin
                    cmd.scan_inc = 1'b1;
                    state_next   = ST_RD;
                end
            end
            ST_FIN: begin
                if (stat.pend) begin
                    state_next = ST_PUSHP;
                end else if (stat.last && !stat.cur_zero) begin
                    state_next = ST_PUSHF;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PUSHP: begin
                if (stat.out_free) begin
                    cmd.push_pend  = 1'b1;
                    cmd.push_final = stat.last && stat.cur_zero;
                    if (stat.last && !stat.cur_zero) begin
                        state_next = ST_PUSHF;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PUSHF: begin
                if (stat.out_free) begin
                    cmd.push_flush = 1'b1;
                    cmd.push_final = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.clear_stream = stat.last;
                state_next       = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// File: rtl/lzwu_dpath.sv
// Datapath of the LZW compressor: string state, dictionary scan, result register.
// Depends on lzwu_pkg and lzwu_ram.
module lzwu_dpath #(
    parameter int CODE_BITS      = lzwu_pkg::CODE_BITS_DEF,
    parameter int MAX_STRING_LEN = lzwu_pkg::MAX_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [lzwu_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lzwu_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [lzwu_pkg::OUT_USER_W-1:0]   m_tuser,
    output logic                              m_tlast,
    input  lzwu_pkg::lzwu_cmd_t               cmd,
    output lzwu_pkg::lzwu_stat_t              stat
);
    import lzwu_pkg::*;

    localparam int DEPTH  = 1 << CODE_BITS;
    localparam int NF_W   = CODE_BITS + 1;
    localparam int ENT_W  = CODE_BITS + SYM_W;

    logic [SYM_W-1:0]     sym_reg;
    logic                 last_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [CODE_BITS-1:0] cur_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [NF_W-1:0]      nf_reg;
    logic [CODE_BITS-1:0] scan_reg;
    logic                 pend_reg;
    logic                 pend_bad_reg;
    logic [CODE_BITS-1:0] pend_code_reg;
    logic                 ov_reg;
    logic [OUT_CODE_W-1:0] oc_reg;
    logic                 ob_reg;
    logic                 ol_reg;

    logic [ENT_W-1:0]     rd_data;
    logic [ENT_W-1:0]     wr_data;
    logic                 wr_en;
    logic [CODE_BITS-1:0] base_ext;
    logic [LEN_W:0]       len_inc;
    logic [NF_W-1:0]      scan_inc;
    logic [CODE_BITS-1:0] push_code;
    logic [CODE_BITS+OUT_CODE_W-1:0] push_wide;

    assign base_ext  = {{(CODE_BITS-BASE_W){1'b0}}, base_reg};
    assign len_inc   = {1'b0, len_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign scan_inc  = {1'b0, scan_reg} + {{CODE_BITS{1'b0}}, 1'b1};
    assign wr_en     = cmd.take_miss && !nf_reg[CODE_BITS];
    assign wr_data   = {cur_reg, sym_reg};
    assign push_code = cmd.push_flush ? cur_reg : pend_code_reg;
    assign push_wide = {{OUT_CODE_W{1'b0}}, push_code};

    lzwu_ram #(
        .WIDTH(ENT_W),
        .DEPTH(DEPTH)
    ) u_dict (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(nf_reg[CODE_BITS-1:0]),
        .wr_data(wr_data),
        .rd_en  (cmd.rd_en),
        .rd_addr(scan_reg),
        .rd_data(rd_data)
    );

    always_comb begin
        stat            = '0;
        stat.b_zero     = (base_reg == '0);
        stat.cur_zero   = (cur_reg == '0);
        stat.dict_empty = (nf_reg == NF_W'(FIRST_FREE));
        stat.hit        = (rd_data[ENT_W-1:SYM_W] == cur_reg) &&
                          (rd_data[SYM_W-1:0] == sym_reg);
        stat.scan_last  = (scan_inc >= nf_reg);
        stat.last       = last_reg;
        stat.pend       = pend_reg;
        stat.out_free   = !ov_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sym_reg  <= s_tdata;
            last_reg <= s_tlast;
            base_reg <= base_code(s_tdata);
        end
        if (cmd.scan_start) begin
            scan_reg <= CODE_BITS'(FIRST_FREE);
        end else if (cmd.scan_inc) begin
            scan_reg <= scan_inc[CODE_BITS-1:0];
        end
        if (cmd.bad_res) begin
            pend_code_reg <= '0;
            pend_bad_reg  <= 1'b1;
        end else if (cmd.take_miss) begin
            pend_code_reg <= cur_reg;
            pend_bad_reg  <= 1'b0;
        end else if (cmd.take_hit) begin
            pend_code_reg <= scan_reg;
            pend_bad_reg  <= 1'b0;
        end
        if (cmd.push_pend || cmd.push_flush) begin
            oc_reg <= push_wide[OUT_CODE_W-1:0];
            ob_reg <= cmd.push_pend && pend_bad_reg;
            ol_reg <= cmd.push_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            len_reg  <= '0;
            nf_reg   <= NF_W'(FIRST_FREE);
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            if (cmd.accept) begin
                pend_reg <= 1'b0;
            end
            if (cmd.bad_res) begin
                pend_reg <= 1'b1;
            end
            if (cmd.set_base) begin
                cur_reg <= base_ext;
                len_reg <= LEN_W'(1);
            end
            if (cmd.take_miss) begin
                pend_reg <= 1'b1;
                cur_reg  <= base_ext;
                len_reg  <= LEN_W'(1);
                if (!nf_reg[CODE_BITS]) begin
                    nf_reg <= nf_reg + NF_W'(1);
                end
            end
            if (cmd.take_hit) begin
                if (len_inc >= (LEN_W+1)'(MAX_STRING_LEN)) begin
                    pend_reg <= 1'b1;
                    cur_reg  <= '0;
                    len_reg  <= '0;
                end else begin
                    cur_reg <= scan_reg;
                    len_reg <= len_inc[LEN_W-1:0];
                end
            end
            if (cmd.clear_stream) begin
                cur_reg <= '0;
                len_reg <= '0;
                nf_reg  <= NF_W'(FIRST_FREE);
            end
            if (cmd.push_pend || cmd.push_flush) begin
                ov_reg <= 1'b1;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_CODE_W){1'b0}}, oc_reg};
    assign m_tuser  = ob_reg;
    assign m_tlast  = ol_reg;
endmodule

// File: tb/tb_lzw_utf8_compressor_top.sv
// Self-checking testbench for the LZW UTF-8 compressor top level.
// Predicts every emitted code in its own dictionary model and checks the stream.
// Depends on rtl/lzwu_pkg.sv and rtl/lzw_utf8_compressor_top.sv.
`timescale 1ns / 1ps

module tb_lzw_utf8_compressor_top;
    import lzwu_pkg::*;

    localparam int DICT_DEPTH = 1 << CODE_BITS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [OUT_CODE_W-1:0] code;
        logic                  bad_symbol;
        logic                  final_res;
    } lzw_code_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    logic [OUT_CODE_W-1:0] dict_prefix [DICT_DEPTH];
    logic [SYM_W-1:0]      dict_symbol [DICT_DEPTH];
    int unsigned           next_code;
    logic [OUT_CODE_W-1:0] string_code;
    int unsigned           string_len;

    lzw_code_t pending_codes[$];
    int        errors;
    int        burst_left;
    bit        no_gaps;
    bit        hold_request;
    int        idle_cycles;

    lzw_utf8_compressor_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic logic [7:0] symbol_base(input logic [SYM_W-1:0] s);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = s[15:8];
        lo = s[7:0];
        if (hi == 8'h00 && lo >= 8'h01 && lo <= 8'h7f) return lo;
        if (lo >= 8'h80 && lo <= 8'hbf) begin
            if (hi == 8'hc2) return 8'd128 + (lo - 8'h80);
            if (hi == 8'hc3) return 8'd192 + (lo - 8'h80);
        end
        return 8'd0;
    endfunction

    function automatic void push_code(input logic [OUT_CODE_W-1:0] c, input logic bad);
        lzw_code_t r;
        r.code = c;
        r.bad_symbol = bad;
        r.final_res = 1'b0;
        pending_codes.push_back(r);
    endfunction

    function automatic void predict_codes(input logic [SYM_W-1:0] s, input logic eod);
        logic [7:0] b;
        int unsigned hit;
        int n;
        b = symbol_base(s);
        n = 0;
        if (b == 0) begin
            push_code('0, 1'b1);
            n++;
        end else if (string_code == 0) begin
            string_code = OUT_CODE_W'(b);
            string_len = 1;
        end else begin
            hit = 0;
            for (int unsigned c = FIRST_FREE; c < next_code; c++) begin
                if (dict_prefix[c] == string_code && dict_symbol[c] == s) begin
                    hit = c;
                    break;
                end
            end
            if (hit != 0) begin
                string_code = OUT_CODE_W'(hit);
                string_len++;
                if (string_len >= MAX_LEN_DEF) begin
                    push_code(string_code, 1'b0);
                    n++;
                    string_code = 0;
                    string_len = 0;
                end
            end else begin
                push_code(string_code, 1'b0);
                n++;
                if (next_code < DICT_DEPTH) begin
                    dict_prefix[next_code] = string_code;
                    dict_symbol[next_code] = s;
                    next_code++;
                end
                string_code = OUT_CODE_W'(b);
                string_len = 1;
            end
        end
        if (eod) begin
            if (string_code != 0) begin
                push_code(string_code, 1'b0);
                n++;
            end
            if (n > 0) pending_codes[pending_codes.size()-1].final_res = 1'b1;
            string_code = 0;
            string_len = 0;
            next_code = FIRST_FREE;
        end
    endfunction

    task automatic send_symbol(input logic [SYM_W-1:0] s, input logic eod);
        s_tdata = s;
        s_tlast = eod;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_codes(s, eod);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if (!no_gaps) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
    endtask

    function automatic logic [SYM_W-1:0] any_good_symbol();
        case ($urandom_range(0, 2))
            0: return 16'(($urandom_range(1, 127)));
            1: return {8'hc2, 8'(($urandom_range(128, 191)))};
            default: return {8'hc3, 8'(($urandom_range(128, 191)))};
        endcase
    endfunction

    task automatic test_alphabet_edges();
        send_symbol(16'h0041, 1'b1);
        send_symbol(16'h0000, 1'b1);
        send_symbol(16'h0001, 1'b0);
        send_symbol(16'h007f, 1'b0);
        send_symbol(16'h0080, 1'b0);
        send_symbol(16'hc280, 1'b0);
        send_symbol(16'hc2bf, 1'b0);
        send_symbol(16'hc27f, 1'b0);
        send_symbol(16'hc2c0, 1'b0);
        send_symbol(16'hc380, 1'b0);
        send_symbol(16'hc3bf, 1'b0);
        send_symbol(16'h017f, 1'b0);
        send_symbol(16'hc480, 1'b0);
        send_symbol(16'hffff, 1'b0);
        send_symbol(16'h0001, 1'b0);
        send_symbol(16'h007f, 1'b0);
        send_symbol(16'h0001, 1'b0);
        send_symbol(16'h007f, 1'b0);
        send_symbol(16'hffff, 1'b1);
        send_symbol(16'hc3bf, 1'b1);
    endtask

    task automatic test_max_length();
        for (int i = 0; i < 150; i++) send_symbol(16'h0061, 1'b0);
        send_symbol(16'h0062, 1'b1);
    endtask

    task automatic test_random_streams(input int count);
        logic [SYM_W-1:0] pool [4];
        int len;
        int sent;
        sent = 0;
        while (sent < count) begin
            foreach (pool[i]) pool[i] = any_good_symbol();
            len = $urandom_range(1, 40);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                logic [SYM_W-1:0] s;
                case ($urandom_range(0, 19))
                    0: s = 16'($urandom());
                    1: s = any_good_symbol();
                    default: s = pool[$urandom_range(0, 3)];
                endcase
                send_symbol(s, i == len - 1);
            end
            sent += len;
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        no_gaps = 1'b1;
        for (int i = 0; i < 40; i++) send_symbol(16'($urandom_range(1, 8)), i == 39);
        no_gaps = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready = 1'b0;
        end else if (hold_request) begin
            m_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
            hold_request = 1'b0;
        end else begin
            case (($urandom() >> 6) % 3)
                0: m_tready = 1'b1;
                1: m_tready = ($urandom_range(0, 9) < 7);
                default: m_tready = ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        lzw_code_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected item: code %0d", m_tdata[OUT_CODE_W-1:0]);
                errors++;
            end else begin
                e = pending_codes.pop_front();
                if (m_tdata != OUT_DATA_W'(e.code)) begin
                    $error("code: expected %0d, actual %0d", e.code, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== e.bad_symbol) begin
                    $error("bad_symbol: expected %0d, actual %0d", e.bad_symbol, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== e.final_res) begin
                    $error("final_res: expected %0d, actual %0d", e.final_res, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else if (++idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        errors = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        hold_request = 1'b0;
        idle_cycles = 0;
        next_code = FIRST_FREE;
        string_code = '0;
        string_len = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_alphabet_edges();
        test_max_length();
        test_output_backpressure();
        test_random_streams(450);
        s_tvalid = 1'b0;
        s_tlast = 1'b0;

        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending_codes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
